// ===== hdl/maem_pkg.sv =====
// ----------------------------------------------------------------------------
// maem_pkg
// Shared widths, codes, command structs and helpers of the matrix engine.
// ----------------------------------------------------------------------------
package maem_pkg;

	localparam int MAX_ROWS_DEF = 8;
	localparam int MAX_COLS_DEF = 8;

	localparam int IDX_W      = 3;
	localparam int CNT_W      = 4;
	localparam int DATA_W     = 32;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int PROD_W     = 64;
	localparam int FRAC_W     = 16;
	localparam int TERM_W     = PROD_W - FRAC_W;
	localparam int ACC_W      = 52;

	typedef enum logic [CMD_W-1:0] {
		CMD_WR_A    = 2'd0,
		CMD_WR_B    = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_MUL = 2'd1,
		OP_MAT = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OPERATION  = 2'd0,
		REG_NUM_ROWS   = 2'd1,
		REG_INNER_COLS = 2'd2,
		REG_OUT_COLS   = 2'd3
	} reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic             first_k;
		logic             last_k;
		logic             last;
		logic             is_add;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} tag_t;

	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic [IDX_W-1:0] wr_row;
		logic [IDX_W-1:0] wr_col;
		logic             issue;
		logic [IDX_W-1:0] a_row;
		logic [IDX_W-1:0] a_col;
		logic [IDX_W-1:0] b_row;
		logic [IDX_W-1:0] b_col;
		tag_t             tag;
	} dp_cmd_t;

	typedef struct packed {
		logic adv;
	} dp_status_t;

	function automatic logic [CNT_W-1:0] fit_cnt(input logic [CNT_W-1:0] v,
			input logic [CNT_W-1:0] bound);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > bound) begin
			r = bound;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== hdl/maem_in_if.sv =====
// ----------------------------------------------------------------------------
// maem_in_if
// Input item channel: load and compute commands.
// ----------------------------------------------------------------------------
interface maem_in_if
	import maem_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [DATA_W-1:0] element_value;

	modport source (output valid, cmd, row_index, col_index, element_value, input ready);
	modport sink (input valid, cmd, row_index, col_index, element_value, output ready);
endinterface

// ===== hdl/maem_out_if.sv =====
// ----------------------------------------------------------------------------
// maem_out_if
// Result channel: one result element per beat.
// ----------------------------------------------------------------------------
interface maem_out_if
	import maem_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         result_row;
	logic [IDX_W-1:0]         result_col;
	logic signed [DATA_W-1:0] result_value;
	logic                     last_flag;

	modport source (output valid, result_row, result_col, result_value, last_flag,
		input ready);
	modport sink (input valid, result_row, result_col, result_value, last_flag,
		output ready);
endinterface

// ===== hdl/maem_cfg_if.sv =====
// ----------------------------------------------------------------------------
// maem_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface maem_cfg_if
	import maem_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/maem_ram.sv =====
// ----------------------------------------------------------------------------
// maem_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module maem_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/maem_ctrl.sv =====
// ----------------------------------------------------------------------------
// maem_ctrl
// Controller: configuration registers, command decode and the row, column
// and inner index walk of a compute.
// ----------------------------------------------------------------------------
module maem_ctrl
	import maem_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	maem_in_if.sink    items,
	maem_cfg_if.sink   cfg,
	output dp_cmd_t    dp_cmd,
	input  dp_status_t dp_status
);
	localparam int MIN_DIM = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;

	state_t state_q, state_d;
	logic [1:0]       op_q;
	logic [CNT_W-1:0] rows_q, inner_q, outc_q;
	logic [CNT_W-1:0] i_q, j_q, k_q, i_d, j_d, k_d;
	logic [CNT_W-1:0] nr_q, nk_q, nc_q, nr_d, nk_d, nc_d;
	logic             is_add_q, is_mat_q, is_add_d, is_mat_d;
	logic             accept, in_range, last_k, last_i, last_j;

	assign cfg.ready   = 1'b1;
	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign in_range    = ({1'b0, items.row_index} < CNT_W'(MAX_ROWS))
		&& ({1'b0, items.col_index} < CNT_W'(MAX_COLS));

	assign last_k = !is_mat_q || (k_q == nk_q - 1'b1);
	assign last_j = (j_q == nc_q - 1'b1);
	assign last_i = (i_q == nr_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_ADD;
			rows_q  <= CNT_W'(1);
			inner_q <= CNT_W'(1);
			outc_q  <= CNT_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_OPERATION:  op_q    <= cfg.data[1:0];
				REG_NUM_ROWS:   rows_q  <= cfg.data;
				REG_INNER_COLS: inner_q <= cfg.data;
				REG_OUT_COLS:   outc_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			nr_q     <= CNT_W'(1);
			nk_q     <= CNT_W'(1);
			nc_q     <= CNT_W'(1);
			is_add_q <= 1'b0;
			is_mat_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			i_q      <= i_d;
			j_q      <= j_d;
			k_q      <= k_d;
			nr_q     <= nr_d;
			nk_q     <= nk_d;
			nc_q     <= nc_d;
			is_add_q <= is_add_d;
			is_mat_q <= is_mat_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		k_d      = k_q;
		nr_d     = nr_q;
		nk_d     = nk_q;
		nc_d     = nc_q;
		is_add_d = is_add_q;
		is_mat_d = is_mat_q;
		dp_cmd   = '0;
		dp_cmd.wr_row = items.row_index;
		dp_cmd.wr_col = items.col_index;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (items.cmd)
						CMD_WR_A: dp_cmd.wr_a = in_range;
						CMD_WR_B: dp_cmd.wr_b = in_range;
						CMD_COMPUTE: begin
							if (op_q == OP_ADD || op_q == OP_MUL || op_q == OP_MAT) begin
								state_d  = ST_RUN;
								i_d      = '0;
								j_d      = '0;
								k_d      = '0;
								is_add_d = (op_q == OP_ADD);
								is_mat_d = (op_q == OP_MAT);
								nr_d     = fit_cnt(rows_q, CNT_W'(MAX_ROWS));
								if (op_q == OP_MAT) begin
									nk_d = fit_cnt(inner_q, CNT_W'(MIN_DIM));
									nc_d = fit_cnt(outc_q, CNT_W'(MAX_COLS));
								end else begin
									nk_d = fit_cnt(inner_q, CNT_W'(MAX_COLS));
									nc_d = nk_d;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				if (dp_status.adv) begin
					dp_cmd.issue       = 1'b1;
					dp_cmd.a_row       = i_q[IDX_W-1:0];
					dp_cmd.b_col       = j_q[IDX_W-1:0];
					if (is_mat_q) begin
						dp_cmd.a_col = k_q[IDX_W-1:0];
						dp_cmd.b_row = k_q[IDX_W-1:0];
					end else begin
						dp_cmd.a_col = j_q[IDX_W-1:0];
						dp_cmd.b_row = i_q[IDX_W-1:0];
					end
					dp_cmd.tag.first_k = (k_q == '0);
					dp_cmd.tag.last_k  = last_k;
					dp_cmd.tag.last    = last_k && last_j && last_i;
					dp_cmd.tag.is_add  = is_add_q;
					dp_cmd.tag.row     = i_q[IDX_W-1:0];
					dp_cmd.tag.col     = j_q[IDX_W-1:0];
					if (!last_k) begin
						k_d = k_q + 1'b1;
					end else begin
						k_d = '0;
						if (!last_j) begin
							j_d = j_q + 1'b1;
						end else begin
							j_d = '0;
							if (!last_i) begin
								i_d = i_q + 1'b1;
							end else begin
								i_d     = '0;
								state_d = ST_IDLE;
							end
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== hdl/maem_dp.sv =====
// ----------------------------------------------------------------------------
// maem_dp
// Datapath: element stores, adder, multiplier, accumulator, saturation and the
// result output register.
// ----------------------------------------------------------------------------
module maem_dp
	import maem_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  dp_cmd,
	output dp_status_t               dp_status,
	input  logic signed [DATA_W-1:0] element_value,
	maem_out_if.source               results
);
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(signed'(32'sh7FFF_FFFF));
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(signed'(32'sh8000_0000));

	logic              adv;
	logic [AW-1:0]     waddr, a_raddr, b_raddr;
	logic [DATA_W-1:0] a_rd, b_rd;

	logic                     valid_s1, valid_s2, out_valid_q;
	tag_t                     tag_s1, tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [DATA_W:0]   sum_s2;
	logic signed [TERM_W-1:0] prod_term, term;
	logic signed [ACC_W-1:0]  acc_q, acc_base, acc_next;
	logic signed [DATA_W-1:0] sat_val;
	logic [IDX_W-1:0]         row_q, col_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     last_q;

	assign adv           = !out_valid_q || results.ready;
	assign dp_status.adv = adv;

	assign waddr   = AW'(int'(dp_cmd.wr_row) * MAX_COLS + int'(dp_cmd.wr_col));
	assign a_raddr = AW'(int'(dp_cmd.a_row) * MAX_COLS + int'(dp_cmd.a_col));
	assign b_raddr = AW'(int'(dp_cmd.b_row) * MAX_COLS + int'(dp_cmd.b_col));

	maem_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(AW)) u_store_a (
		.clk   (clk),
		.we    (dp_cmd.wr_a),
		.waddr (waddr),
		.wdata (element_value),
		.re    (dp_cmd.issue),
		.raddr (a_raddr),
		.rdata (a_rd)
	);

	maem_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(AW)) u_store_b (
		.clk   (clk),
		.we    (dp_cmd.wr_b),
		.waddr (waddr),
		.wdata (element_value),
		.re    (dp_cmd.issue),
		.raddr (b_raddr),
		.rdata (b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= dp_cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1  <= dp_cmd.tag;
			tag_s2  <= tag_s1;
			prod_s2 <= PROD_W'(signed'(a_rd)) * PROD_W'(signed'(b_rd));
			sum_s2  <= (DATA_W+1)'(signed'(a_rd)) + (DATA_W+1)'(signed'(b_rd));
		end
	end

	assign prod_term = prod_s2[PROD_W-1:FRAC_W];
	assign term      = tag_s2.is_add ? TERM_W'(sum_s2) : prod_term;
	assign acc_base  = tag_s2.first_k ? '0 : acc_q;
	assign acc_next  = acc_base + ACC_W'(term);

	always_comb begin
		if (acc_next > SAT_MAX) begin
			sat_val = SAT_MAX[DATA_W-1:0];
		end else if (acc_next < SAT_MIN) begin
			sat_val = SAT_MIN[DATA_W-1:0];
		end else begin
			sat_val = acc_next[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			acc_q <= acc_next;
			if (tag_s2.last_k) begin
				row_q   <= tag_s2.row;
				col_q   <= tag_s2.col;
				value_q <= sat_val;
				last_q  <= tag_s2.last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && valid_s2 && tag_s2.last_k) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.result_row   = row_q;
	assign results.result_col   = col_q;
	assign results.result_value = value_q;
	assign results.last_flag    = last_q;
endmodule

// ===== hdl/matrix_add_mul_engine.sv =====
// ----------------------------------------------------------------------------
// matrix_add_mul_engine
// Q16.16 matrix engine: elementwise add, elementwise product and matrix
// product of two MAX_ROWS x MAX_COLS stores; saturated results, row-major order.
//
// channel  dir  beat
// items    in   cmd, row_index, col_index, element_value
// results  out  result_row, result_col, result_value, last_flag
// cfg      in   index, data (operation, num_rows, inner_cols, out_cols)
//
// A compute holds items off while the controller walks the stores: one read
// of each store per cycle unless the results beat stalls, rows x cols reads
// for the elementwise operations and rows x cols x inner reads for the matrix
// product, passing through the read, multiply and accumulate stages.
// A stalled results beat freezes the read, multiply and accumulate stages.
// Reset clears control state only; store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module matrix_add_mul_engine
	import maem_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	maem_in_if.sink     items,
	maem_out_if.source  results,
	maem_cfg_if.sink    cfg
);
	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	maem_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cfg       (cfg),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status)
	);

	maem_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.dp_cmd        (dp_cmd),
		.dp_status     (dp_status),
		.element_value (items.element_value),
		.results       (results)
	);
endmodule
